>>> src/f2i_pkg.sv
// shared types and constants for the float to int32 converter
`timescale 1ns / 1ps
`default_nettype none
package f2i_pkg;

    localparam logic [7:0]  EXP_HALF      = 8'h7E;
    localparam logic [7:0]  EXP_SAT       = 8'd158;
    localparam logic [7:0]  EXP_NAN       = 8'hFF;
    localparam logic [7:0]  SHIFT_BASE    = 8'd157;
    localparam logic [31:0] INT_POS_LIMIT = 32'h7FFFFFFF;
    localparam logic [31:0] INT_NEG_LIMIT = 32'h80000000;
    localparam int          PIPE_DEPTH    = 4;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        zero;
        logic        sat;
        logic [4:0]  sh;
        logic [31:0] mant;
        logic        sticky;
    } stage_t;

endpackage
`default_nettype wire

>>> src/f2i_decode.sv
// first stage: field split, range classification and shift amount
`timescale 1ns / 1ps
`default_nettype none
module f2i_decode
    import f2i_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] float_bits,
    output stage_t           dec_out
);

    stage_t dec_reg;
    stage_t dec_next;
    logic [7:0] expf;
    logic [7:0] sh_full;

    always_comb
    begin
        expf            = float_bits[30:23];
        sh_full         = SHIFT_BASE - expf;
        dec_next.valid  = in_valid;
        dec_next.neg    = float_bits[31];
        dec_next.zero   = (expf < EXP_HALF);
        dec_next.sat    = (expf >= EXP_SAT);
        dec_next.sh     = sh_full[4:0];
        dec_next.mant   = {1'b1, float_bits[22:0], 8'h00};
        dec_next.sticky = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
        end
        else
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_out = dec_reg;

endmodule
`default_nettype wire

>>> src/f2i_align.sv
// two stages of right shift with sticky collection
`timescale 1ns / 1ps
`default_nettype none
module f2i_align
    import f2i_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire stage_t align_in,
    output stage_t      align_out
);

    stage_t hi_reg;
    stage_t hi_next;
    stage_t lo_reg;
    stage_t lo_next;

    // coarse shift by 16 and 8
    always_comb
    begin
        hi_next = align_in;
        if (align_in.sh[4])
        begin
            hi_next.sticky = hi_next.sticky | (|hi_next.mant[15:0]);
            hi_next.mant   = {16'h0000, hi_next.mant[31:16]};
        end
        if (align_in.sh[3])
        begin
            hi_next.sticky = hi_next.sticky | (|hi_next.mant[7:0]);
            hi_next.mant   = {8'h00, hi_next.mant[31:8]};
        end
    end

    // fine shift by 4, 2 and 1
    always_comb
    begin
        lo_next = hi_reg;
        if (hi_reg.sh[2])
        begin
            lo_next.sticky = lo_next.sticky | (|lo_next.mant[3:0]);
            lo_next.mant   = {4'h0, lo_next.mant[31:4]};
        end
        if (hi_reg.sh[1])
        begin
            lo_next.sticky = lo_next.sticky | (|lo_next.mant[1:0]);
            lo_next.mant   = {2'b00, lo_next.mant[31:2]};
        end
        if (hi_reg.sh[0])
        begin
            lo_next.sticky = lo_next.sticky | lo_next.mant[0];
            lo_next.mant   = {1'b0, lo_next.mant[31:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign align_out = lo_reg;

endmodule
`default_nettype wire

>>> src/f2i_round.sv
// last stage: round to nearest even, sign and saturation
`timescale 1ns / 1ps
`default_nettype none
module f2i_round
    import f2i_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stage_t             round_in,
    output logic                    done,
    output logic signed [31:0]      int_value
);

    logic        done_reg;
    logic        done_next;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic [31:0] whole;
    logic        half;
    logic        up;

    always_comb
    begin
        whole     = {1'b0, round_in.mant[31:1]};
        half      = round_in.mant[0];
        up        = half & (round_in.sticky | whole[0]);
        done_next = round_in.valid;
        if (round_in.zero)
        begin
            value_next = 32'h0;
        end
        else if (round_in.sat)
        begin
            value_next = round_in.neg ? INT_NEG_LIMIT : INT_POS_LIMIT;
        end
        else if (!round_in.neg)
        begin
            value_next = whole + {31'h0, up};
        end
        else
        begin
            value_next = up ? ~whole : (32'h0 - whole);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign done      = done_reg;
    assign int_value = value_reg;

endmodule
`default_nettype wire

>>> src/float32_to_int32_convert.sv
// top level of the float32 to int32 converter
`timescale 1ns / 1ps
`default_nettype none
// Converts an IEEE single-precision bit pattern to a signed 32-bit integer,
// rounding to nearest with ties to even; magnitudes below one half give 0,
// and out-of-range values, infinities and NaNs saturate by sign. A word is
// taken on every cycle with start high; busy never rises. Each result appears
// on int_value with done high for one cycle, in order, after its word has
// passed one decode stage, two shift stages of the five-step sticky
// shifter and one rounding stage.
module float32_to_int32_convert
    import f2i_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        float_bits,
    output logic                    done,
    output logic signed [31:0]      int_value
);

    stage_t dec_stage;
    stage_t align_stage;

    assign busy = 1'b0;

    f2i_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .float_bits (float_bits),
        .dec_out    (dec_stage)
    );

    f2i_align u_align
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .align_in   (dec_stage),
        .align_out  (align_stage)
    );

    f2i_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .round_in   (align_stage),
        .done       (done),
        .int_value  (int_value)
    );

`ifndef ASSERT_OFF
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result word without matching start");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start ##PIPE_DEPTH 1'b1 |-> done)
        else $error("started word lost in pipeline");

    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(float_bits[30:23], PIPE_DEPTH) < EXP_HALF)
        |-> int_value == 32'sh0)
        else $error("small magnitude not zero");

    a_nan_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(float_bits[30:23], PIPE_DEPTH) == EXP_NAN)
        && !$past(float_bits[31], PIPE_DEPTH)
        |-> int_value == INT_POS_LIMIT)
        else $error("positive special value not saturated");
`endif

endmodule
`default_nettype wire
